### design/reconstruction_filter_weight_macros.svh
// Assertion macros shared by the design files.
`ifndef RECONSTRUCTION_FILTER_WEIGHT_MACROS_SVH
`define RECONSTRUCTION_FILTER_WEIGHT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RFW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rfw assertion failed");
`define RFW_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rfw assertion failed");
`else
`define RFW_ASSERT(lbl, clk, rst_n, prop)
`define RFW_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### design/rfw_pkg.sv
package rfw_pkg;

	localparam int NUM_STAGES = 10;

	typedef enum logic [2:0] {
		MODE_BOX       = 3'd0,
		MODE_TENT      = 3'd1,
		MODE_GAUSS     = 3'd2,
		MODE_MITCHELL  = 3'd3,
		MODE_QUADRATIC = 3'd4,
		MODE_CUBIC     = 3'd5,
		MODE_CATMULL   = 3'd6,
		MODE_UNKNOWN   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [NUM_STAGES:1] en;
		logic [NUM_STAGES:1] vld;
	} pipe_ctl_t;

	typedef enum logic [1:0] {
		DIV_BY_1,
		DIV_BY_3,
		DIV_BY_9
	} div_t;

	typedef struct packed {
		logic signed [7:0] k0;
		logic signed [7:0] k1;
		logic signed [7:0] k2;
		logic signed [7:0] k3;
		logic [1:0]        sh;
		div_t              dv;
		logic [4:0]        d;
	} coef_t;

	// exp(-4.5 x^2) as 2^-u, u in Q16
	localparam logic [18:0] GAUSS_EXP_K = 19'd425468;
	localparam logic [11:0] GAUSS_PEAK  = 12'd4085;
	localparam logic [6:0]  HORNER_C5   = 7'd87;
	localparam logic [9:0]  HORNER_C4   = 10'd630;
	localparam logic [11:0] HORNER_C3   = 12'd3638;
	localparam logic [13:0] HORNER_C2   = 14'd15743;
	localparam logic [15:0] HORNER_C1   = 16'd45426;
	localparam logic [16:0] HORNER_C0   = 17'd65536;

	// ceil(2^24 / 5): exact floor division for numerators below 2^22
	localparam logic [21:0] RECIP_5 = 22'd3355444;

	function automatic logic [24:0] recip_q24(div_t dv);
		logic [24:0] r;
		case (dv)
			DIV_BY_3: r = 25'd5592406;
			DIV_BY_9: r = 25'd1864136;
			default:  r = 25'd16777216;
		endcase
		return r;
	endfunction

	// Piece coefficients over denominator d = 2^sh * divisor
	function automatic coef_t spline_coef(mode_t m, logic hi);
		coef_t c;
		c = '{k0: 8'sd0, k1: 8'sd0, k2: 8'sd0, k3: 8'sd0,
		      sh: 2'd0, dv: DIV_BY_1, d: 5'd1};
		unique case (m)
			MODE_MITCHELL: begin
				c = hi ? '{k0: 8'sd32, k1: -8'sd60, k2: 8'sd36, k3: -8'sd7,
				           sh: 2'd1, dv: DIV_BY_9, d: 5'd18}
				       : '{k0: 8'sd16, k1: 8'sd0, k2: -8'sd36, k3: 8'sd21,
				           sh: 2'd1, dv: DIV_BY_9, d: 5'd18};
			end
			MODE_QUADRATIC: begin
				c = hi ? '{k0: 8'sd9, k1: -8'sd12, k2: 8'sd4, k3: 8'sd0,
				           sh: 2'd3, dv: DIV_BY_1, d: 5'd8}
				       : '{k0: 8'sd6, k1: 8'sd0, k2: -8'sd8, k3: 8'sd0,
				           sh: 2'd3, dv: DIV_BY_1, d: 5'd8};
			end
			MODE_CUBIC: begin
				c = hi ? '{k0: 8'sd8, k1: -8'sd12, k2: 8'sd6, k3: -8'sd1,
				           sh: 2'd1, dv: DIV_BY_3, d: 5'd6}
				       : '{k0: 8'sd4, k1: 8'sd0, k2: -8'sd6, k3: 8'sd3,
				           sh: 2'd1, dv: DIV_BY_3, d: 5'd6};
			end
			MODE_CATMULL: begin
				c = hi ? '{k0: 8'sd4, k1: -8'sd8, k2: 8'sd5, k3: -8'sd1,
				           sh: 2'd1, dv: DIV_BY_1, d: 5'd2}
				       : '{k0: 8'sd2, k1: 8'sd0, k2: -8'sd5, k3: 8'sd3,
				           sh: 2'd1, dv: DIV_BY_1, d: 5'd2};
			end
			default: begin
				c.d = 5'd1;
			end
		endcase
		return c;
	endfunction

endpackage

### design/rfw_in_if.sv
interface rfw_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [15:0] x;

	modport source (output valid, output mode, output x, input ready);
	modport sink (input valid, input mode, input x, output ready);
endinterface

### design/rfw_out_if.sv
interface rfw_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] weight;

	modport source (output valid, output weight, input ready);
	modport sink (input valid, input weight, output ready);
endinterface

### design/rfw_ctrl.sv
`include "reconstruction_filter_weight_macros.svh"

module rfw_ctrl import rfw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] vld_d;
	logic [NUM_STAGES:1] en;

	// a stage moves when the output is ready, or when it or some later stage is empty
	for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_en
		assign en[g] = out_ready || !(&vld_q[NUM_STAGES:g]);
	end

	assign vld_d = {vld_q[NUM_STAGES-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_d[k];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

	`RFW_ASSERT(a_full_stall_blocks, clk, arst_n, (&vld_q && !out_ready) |-> !en[1])
	`RFW_ASSERT(a_drain_frees_input, clk, arst_n, (vld_q[NUM_STAGES] && out_ready) |-> en[1])

endmodule

### design/rfw_gauss.sv
`include "reconstruction_filter_weight_macros.svh"

module rfw_gauss import rfw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic [12:0]        a13,
	input  logic               big,
	output logic signed [15:0] weight
);

	logic [25:0] sq_s2;
	logic        zero_s2;
	logic [44:0] prod;

	logic [15:0] f_s3, f_s4, f_s5, f_s6, f_s7;
	logic [3:0]  n_s3, n_s4, n_s5, n_s6, n_s7, n_s8, n_s9;
	logic        zero_s3, zero_s4, zero_s5, zero_s6, zero_s7, zero_s8, zero_s9;

	logic [22:0] m1;
	logic [25:0] m2;
	logic [27:0] m3;
	logic [29:0] m4;
	logic [31:0] m5;
	logic [9:0]  t1_s4;
	logic [11:0] t2_s5;
	logic [13:0] t3_s6;
	logic [15:0] t4_s7;
	logic [16:0] p_s8;
	logic [27:0] gp_s9;
	logic [31:0] rnd;
	logic [31:0] shifted;

	assign prod = sq_s2 * GAUSS_EXP_K;
	assign m1   = f_s3 * HORNER_C5;
	assign m2   = f_s4 * t1_s4;
	assign m3   = f_s5 * t2_s5;
	assign m4   = f_s6 * t3_s6;
	assign m5   = f_s7 * t4_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			sq_s2   <= a13 * a13;
			zero_s2 <= big;
		end
		if (ctl.en[3]) begin
			n_s3    <= prod[43:40];
			f_s3    <= prod[39:24];
			zero_s3 <= zero_s2 | prod[44];
		end
		if (ctl.en[4]) begin
			t1_s4   <= HORNER_C4 - {3'b0, m1[22:16]};
			f_s4    <= f_s3;
			n_s4    <= n_s3;
			zero_s4 <= zero_s3;
		end
		if (ctl.en[5]) begin
			t2_s5   <= HORNER_C3 - {2'b0, m2[25:16]};
			f_s5    <= f_s4;
			n_s5    <= n_s4;
			zero_s5 <= zero_s4;
		end
		if (ctl.en[6]) begin
			t3_s6   <= HORNER_C2 - {2'b0, m3[27:16]};
			f_s6    <= f_s5;
			n_s6    <= n_s5;
			zero_s6 <= zero_s5;
		end
		if (ctl.en[7]) begin
			t4_s7   <= HORNER_C1 - {2'b0, m4[29:16]};
			f_s7    <= f_s6;
			n_s7    <= n_s6;
			zero_s7 <= zero_s6;
		end
		if (ctl.en[8]) begin
			p_s8    <= HORNER_C0 - {1'b0, m5[31:16]};
			n_s8    <= n_s7;
			zero_s8 <= zero_s7;
		end
		if (ctl.en[9]) begin
			gp_s9   <= p_s8 * GAUSS_PEAK;
			n_s9    <= n_s8;
			zero_s9 <= zero_s8;
		end
	end

	// round to nearest on the 2^-(16+n) scale
	always_comb begin
		rnd     = {4'b0, gp_s9} + (32'd1 << (5'd15 + {1'b0, n_s9}));
		shifted = rnd >> (5'd16 + {1'b0, n_s9});
		weight  = zero_s9 ? 16'sd0 : $signed({3'b0, shifted[12:0]});
	end

	`RFW_ASSERT(a_exp2_nonzero, clk, arst_n, ctl.vld[8] |-> (p_s8 != 17'd0))

endmodule

### design/rfw_spline.sv
`include "reconstruction_filter_weight_macros.svh"

module rfw_spline import rfw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic [12:0]        a13,
	input  logic               big,
	input  mode_t              mode,
	output logic signed [15:0] weight
);

	logic [19:0] num5;
	logic [41:0] prod5;
	logic [17:0] s_s2;
	logic        off_s2;
	mode_t       mode_s2;

	logic        quad;
	logic        spl;
	logic        hi;
	logic        beyond;

	logic [16:0] s_s3;
	logic [33:0] sq_s3;
	coef_t       coef_s3;
	logic        off_s3;

	logic [50:0]        cube_s4;
	logic signed [25:0] p1_s4;
	logic signed [42:0] p2_s4;
	coef_t              coef_s4;
	logic               off_s4;

	logic signed [59:0] k0e, p1e, p2e, p3e, num_d;
	logic signed [59:0] num_s5;
	coef_t              coef_s5;
	logic               off_s5;

	logic [59:0] mag;
	logic [59:0] rsum;
	logic [19:0] v_s6;
	logic [1:0]  sh_s6;
	div_t        dv_s6;
	logic        neg_s6;
	logic        off_s6;

	logic [19:0]        vs;
	logic [44:0]        prodq;
	logic [20:0]        q;
	logic signed [15:0] w_d;
	logic signed [15:0] w_s7, w_s8, w_s9;

	// s = 1.6|x| in Q16 = floor((128a + 2) / 5)
	assign num5  = {a13, 7'b0} + 20'd2;
	assign prod5 = num5 * RECIP_5;

	always_comb begin
		quad   = (mode_s2 == MODE_QUADRATIC);
		spl    = (mode_s2 == MODE_MITCHELL) || (mode_s2 == MODE_QUADRATIC) ||
		         (mode_s2 == MODE_CUBIC) || (mode_s2 == MODE_CATMULL);
		hi     = quad ? (s_s2[16] | s_s2[15]) : s_s2[16];
		beyond = quad ? (s_s2[17] | (s_s2[16] & s_s2[15])) : s_s2[17];
	end

	always_comb begin
		k0e   = 60'(coef_s4.k0);
		p1e   = 60'(p1_s4);
		p2e   = 60'(p2_s4);
		p3e   = coef_s4.k3 * $signed({1'b0, cube_s4});
		num_d = (k0e <<< 48) + (p1e <<< 32) + (p2e <<< 16) + p3e;
	end

	// round half away from zero: floor((|num| + d 2^33) / 2^34) / d
	always_comb begin
		mag  = num_s5[59] ? -num_s5 : num_s5;
		rsum = mag + (60'(coef_s5.d) << 33);
	end

	always_comb begin
		vs    = v_s6 >> sh_s6;
		prodq = vs * recip_q24(dv_s6);
		q     = prodq[44:24];
		if (off_s6) begin
			w_d = 16'sd0;
		end else if (!neg_s6) begin
			w_d = (q > 21'd32767) ? 16'sh7FFF : $signed(q[15:0]);
		end else begin
			w_d = (q > 21'd32767) ? 16'sh8000 : -$signed(q[15:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			s_s2    <= prod5[41:24];
			off_s2  <= big;
			mode_s2 <= mode;
		end
		if (ctl.en[3]) begin
			s_s3    <= s_s2[16:0];
			sq_s3   <= s_s2[16:0] * s_s2[16:0];
			coef_s3 <= spline_coef(mode_s2, hi);
			off_s3  <= off_s2 | beyond | !spl;
		end
		if (ctl.en[4]) begin
			cube_s4 <= sq_s3 * s_s3;
			p1_s4   <= coef_s3.k1 * $signed({1'b0, s_s3});
			p2_s4   <= coef_s3.k2 * $signed({1'b0, sq_s3});
			coef_s4 <= coef_s3;
			off_s4  <= off_s3;
		end
		if (ctl.en[5]) begin
			num_s5  <= num_d;
			coef_s5 <= coef_s4;
			off_s5  <= off_s4;
		end
		if (ctl.en[6]) begin
			v_s6   <= rsum[53:34];
			sh_s6  <= coef_s5.sh;
			dv_s6  <= coef_s5.dv;
			neg_s6 <= num_s5[59];
			off_s6 <= off_s5;
		end
		if (ctl.en[7]) begin
			w_s7 <= w_d;
		end
		if (ctl.en[8]) begin
			w_s8 <= w_s7;
		end
		if (ctl.en[9]) begin
			w_s9 <= w_s8;
		end
	end

	assign weight = w_s9;

	`RFW_ASSERT(a_scaled_fits, clk, arst_n, (ctl.vld[6] && !off_s6) |-> !v_s6[19])

endmodule

### design/reconstruction_filter_weight.sv
// Reconstruction filter weight.
// query carries a filter kind (mode) and a signed Q4.12 distance x; answer
// returns the Q2.14 weight at that distance. Kinds: box, tent, Gaussian,
// Mitchell-Netravali, quadratic and cubic B-spline, Catmull-Rom; mode 7
// gives zero. Both channels use valid/ready; a request moves when both
// are high.
// The pipeline depth is set by the Gaussian path (a squarer, the exponent
// scale, five Horner steps of 2^-f, the peak scale and a rounding shift,
// one multiplier per stage).
// Throughput: one request per cycle with answer ready held high.
// Reset clears every stage's valid bit; the pipeline comes up empty and
// ready.
// A stalled receiver holds the output register; each stage still advances
// while it or a later stage is empty, so requests keep entering until all ten
// stages are full, after which query.ready falls.

`include "reconstruction_filter_weight_macros.svh"

module reconstruction_filter_weight import rfw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rfw_in_if.sink     query,
	rfw_out_if.source  answer
);

	typedef struct packed {
		mode_t              mode;
		logic signed [15:0] bt_w;
	} side_t;

	pipe_ctl_t          ctl;
	logic [16:0]        xe;
	logic [16:0]        a_abs;
	logic [16:0]        a_s1;
	mode_t              mode_s1;
	logic               big;
	logic               near;
	logic [16:0]        tent_v;
	side_t              side_d;
	side_t              side_s [2:9];
	logic signed [15:0] gauss_w;
	logic signed [15:0] spline_w;
	logic signed [15:0] weight_d;
	logic signed [15:0] weight_s10;

	rfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.out_ready (answer.ready),
		.ctl       (ctl)
	);

	assign xe    = {query.x[15], query.x};
	assign a_abs = query.x[15] ? (~xe + 17'd1) : xe;

	assign big    = |a_s1[16:13];
	assign near   = (a_s1 <= 17'd4096);
	assign tent_v = 17'd16384 - {a_s1[14:0], 2'b0};

	always_comb begin
		side_d.mode = mode_s1;
		case (mode_s1)
			MODE_BOX:  side_d.bt_w = near ? 16'sd16384 : 16'sd0;
			MODE_TENT: side_d.bt_w = near ? $signed(tent_v[15:0]) : 16'sd0;
			default:   side_d.bt_w = 16'sd0;
		endcase
	end

	rfw_gauss u_gauss (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a13    (a_s1[12:0]),
		.big    (big),
		.weight (gauss_w)
	);

	rfw_spline u_spline (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a13    (a_s1[12:0]),
		.big    (big),
		.mode   (mode_s1),
		.weight (spline_w)
	);

	always_comb begin
		case (side_s[9].mode) inside
			MODE_BOX, MODE_TENT: weight_d = side_s[9].bt_w;
			MODE_GAUSS:          weight_d = gauss_w;
			MODE_MITCHELL, MODE_QUADRATIC, MODE_CUBIC, MODE_CATMULL:
				weight_d = spline_w;
			default:             weight_d = 16'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			a_s1    <= a_abs;
			mode_s1 <= mode_t'(query.mode);
		end
		if (ctl.en[2]) begin
			side_s[2] <= side_d;
		end
		for (int k = 3; k <= 9; k++) begin
			if (ctl.en[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
		if (ctl.en[NUM_STAGES]) begin
			weight_s10 <= weight_d;
		end
	end

	assign query.ready   = ctl.en[1];
	assign answer.valid  = ctl.vld[NUM_STAGES];
	assign answer.weight = weight_s10;

	`RFW_ASSERT_NXT(a_unknown_zero, clk, arst_n, ctl.vld[9] && ctl.en[NUM_STAGES] && (side_s[9].mode == MODE_UNKNOWN), answer.weight == 16'sd0)

endmodule

### sim/tb_reconstruction_filter_weight.sv
module tb_reconstruction_filter_weight;
	import rfw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		mode_t              mode;
		logic signed [15:0] x;
		bit                 hold;
	} weight_req_t;

	logic clk = 1'b0;
	logic arst_n;

	rfw_in_if  query();
	rfw_out_if answer();

	reconstruction_filter_weight dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.answer (answer)
	);

	weight_req_t        requests_todo[$];
	logic signed [15:0] weights_due[$];
	int                 accepted = 0;
	int                 mismatches = 0;

	always #4 clk = ~clk;

	// cubic over d in Q16 s, rounded once to Q14, halves away from zero
	function automatic longint poly_q14(longint k0, longint k1, longint k2, longint k3,
		longint d, longint s);
		longint num;
		longint den;
		num = k0 * 64'sd281474976710656 + k1 * s * 64'sd4294967296
			+ k2 * s * s * 64'sd65536 + k3 * s * s * s;
		den = d * 64'sd17179869184;
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic logic signed [15:0] filter_weight(mode_t m, logic signed [15:0] x);
		longint a;
		longint s;
		longint u;
		longint n;
		longint f;
		longint t;
		longint p;
		longint w;
		a = (x < 0) ? -longint'(x) : longint'(x);
		s = (a * 128 + 2) / 5;
		w = 0;
		case (m)
			MODE_BOX:  w = (a <= 4096) ? 16384 : 0;
			MODE_TENT: w = (a <= 4096) ? 16384 - 4 * a : 0;
			MODE_GAUSS: begin
				u = (a * a * 425468) >> 24;
				n = u >> 16;
				f = u & 64'hFFFF;
				if (n < 16) begin
					t = 87;
					t = 630 - ((f * t) >> 16);
					t = 3638 - ((f * t) >> 16);
					t = 15743 - ((f * t) >> 16);
					t = 45426 - ((f * t) >> 16);
					p = 65536 - ((f * t) >> 16);
					w = (4085 * p + (64'sd1 << (15 + n))) >> (16 + n);
				end
			end
			MODE_MITCHELL: begin
				if (s < 65536)
					w = poly_q14(16, 0, -36, 21, 18, s);
				else if (s < 131072)
					w = poly_q14(32, -60, 36, -7, 18, s);
			end
			MODE_QUADRATIC: begin
				if (s < 32768)
					w = poly_q14(6, 0, -8, 0, 8, s);
				else if (s < 98304)
					w = poly_q14(9, -12, 4, 0, 8, s);
			end
			MODE_CUBIC: begin
				if (s < 65536)
					w = poly_q14(4, 0, -6, 3, 6, s);
				else if (s < 131072)
					w = poly_q14(8, -12, 6, -1, 6, s);
			end
			MODE_CATMULL: begin
				if (s < 65536)
					w = poly_q14(2, 0, -5, 3, 2, s);
				else if (s < 131072)
					w = poly_q14(4, -8, 5, -1, 2, s);
			end
			default: w = 0;
		endcase
		if (w > 32767)
			w = 32767;
		if (w < -32768)
			w = -32768;
		return w[15:0];
	endfunction

	// no idling while the middle stretch of requests goes through
	function automatic bit pause_now();
		if (accepted >= 700 && accepted < 1000)
			return 1'b0;
		return $urandom_range(99) < 37;
	endfunction

	function automatic void add_req(mode_t m, logic signed [15:0] x, bit hold);
		weight_req_t r;
		r.mode = m;
		r.x = x;
		r.hold = hold;
		requests_todo.push_back(r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		weight_req_t r;
		if (!arst_n) begin
			query.valid <= 1'b0;
			query.mode <= MODE_BOX;
			query.x <= '0;
		end else begin
			if (query.valid && query.ready) begin
				weights_due.push_back(filter_weight(mode_t'(query.mode), query.x));
				accepted++;
			end
			if (!query.valid || query.ready) begin
				if (requests_todo.size() != 0 && !pause_now()
					&& !(requests_todo[0].hold && weights_due.size() != 0)) begin
					r = requests_todo.pop_front();
					query.valid <= 1'b1;
					query.mode <= r.mode;
					query.x <= r.x;
				end else begin
					query.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			answer.ready <= 1'b0;
		end else begin
			if (answer.valid && answer.ready) begin
				if (weights_due.size() == 0) begin
					$display("%0t: unexpected weight, expected none, actual %0d",
						$time, answer.weight);
					mismatches++;
				end else begin
					want = weights_due.pop_front();
					if (answer.weight !== want) begin
						$display("%0t: weight mismatch, expected %0d, actual %0d",
							$time, want, answer.weight);
						mismatches++;
					end
				end
			end
			answer.ready <= !pause_now();
		end
	end

	initial begin
		int   i;
		logic signed [15:0] xv;
		arst_n = 1'b0;

		// box and tent edges
		add_req(MODE_BOX, 16'sd4096, 1'b0);
		add_req(MODE_BOX, -16'sd4097, 1'b0);
		add_req(MODE_TENT, -16'sd4096, 1'b0);
		add_req(MODE_TENT, 16'sd2048, 1'b0);
		// gauss peak and the exponent running out
		add_req(MODE_GAUSS, 16'sd0, 1'b0);
		add_req(MODE_GAUSS, 16'sd6430, 1'b0);
		add_req(MODE_GAUSS, -16'sd6431, 1'b0);
		// spline piece boundaries
		add_req(MODE_MITCHELL, 16'sd2559, 1'b0);
		add_req(MODE_MITCHELL, 16'sd2560, 1'b0);
		add_req(MODE_MITCHELL, 16'sd5119, 1'b0);
		add_req(MODE_MITCHELL, 16'sd5120, 1'b0);
		add_req(MODE_QUADRATIC, 16'sd1279, 1'b0);
		add_req(MODE_QUADRATIC, 16'sd1280, 1'b0);
		add_req(MODE_QUADRATIC, 16'sd3839, 1'b0);
		add_req(MODE_QUADRATIC, 16'sd3840, 1'b0);
		add_req(MODE_CUBIC, 16'sd2560, 1'b0);
		add_req(MODE_CUBIC, -16'sd5119, 1'b0);
		add_req(MODE_CATMULL, 16'sd0, 1'b0);
		add_req(MODE_CATMULL, 16'sd2560, 1'b0);
		add_req(MODE_CATMULL, -16'sd5120, 1'b0);
		add_req(MODE_UNKNOWN, 16'sd1234, 1'b0);
		// most negative and most positive distance
		add_req(MODE_BOX, -16'sd32768, 1'b0);
		add_req(MODE_GAUSS, 16'sd32767, 1'b0);
		add_req(MODE_CATMULL, -16'sd32768, 1'b0);

		for (i = 0; i < 1750; i++) begin
			if ($urandom_range(99) < 70) begin
				xv = 16'($urandom_range(14000));
				if ($urandom_range(1))
					xv = -xv;
			end else begin
				xv = 16'($urandom);
			end
			add_req(mode_t'($urandom_range(7)), xv, i == 0 || i == 900);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_todo.size() != 0 || query.valid)
			@(posedge clk);
		while (weights_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && weights_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/rfw_pkg.sv
design/rfw_in_if.sv
design/rfw_out_if.sv
design/rfw_ctrl.sv
design/rfw_gauss.sv
design/rfw_spline.sv
design/reconstruction_filter_weight.sv
sim/tb_reconstruction_filter_weight.sv
